@@ rtl/wmc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmc_pkg
// Shared types, codes and constants of the watch mode controller.
// ----------------------------------------------------------------------------
package wmc_pkg;

	// item commands
	localparam logic [1:0] CMD_TICK   = 2'd0;
	localparam logic [1:0] CMD_MODE   = 2'd1;
	localparam logic [1:0] CMD_ADJUST = 2'd2;
	localparam logic [1:0] CMD_LIGHT  = 2'd3;

	// display modes
	localparam logic [3:0] MODE_CLOCK      = 4'd0;
	localparam logic [3:0] MODE_CLOCK_EDIT = 4'd1;
	localparam logic [3:0] MODE_WAKE       = 4'd2;
	localparam logic [3:0] MODE_WAKE_EDIT  = 4'd3;
	localparam logic [3:0] MODE_CHRONO     = 4'd4;
	localparam logic [3:0] MODE_COUNTDOWN  = 4'd5;
	localparam logic [3:0] MODE_SENS0      = 4'd6;
	localparam logic [3:0] MODE_SENS1      = 4'd7;
	localparam logic [3:0] MODE_SENS2      = 4'd8;
	localparam logic [3:0] MODE_SENS3      = 4'd9;

	// events
	localparam logic [2:0] EV_NONE         = 3'd0;
	localparam logic [2:0] EV_COMMIT_TIME  = 3'd1;
	localparam logic [2:0] EV_COMMIT_ALARM = 3'd2;
	localparam logic [2:0] EV_DISARM       = 3'd3;
	localparam logic [2:0] EV_TMR_EXPIRED  = 3'd4;

	// time set fields
	localparam logic [2:0] FLD_SEC   = 3'd0;
	localparam logic [2:0] FLD_MIN   = 3'd1;
	localparam logic [2:0] FLD_HOUR  = 3'd2;
	localparam logic [2:0] FLD_DAY   = 3'd3;
	localparam logic [2:0] FLD_MONTH = 3'd4;

	localparam int unsigned TIME_FIELDS = 5;

	localparam logic [12:0] TMR_MAX  = 13'd5940;
	localparam logic [12:0] TMR_MIN  = 13'd600;
	localparam logic [12:0] TMR_STEP = 13'd60;
	localparam logic [12:0] STW_LAST = 13'd5999;

	localparam logic [5:0] SIXTY       = 6'd60;
	localparam logic [4:0] HOURS_DAY   = 5'd24;
	localparam logic [4:0] DAYS_MAX    = 5'd31;
	localparam logic [3:0] MONTHS_YEAR = 4'd12;

	typedef struct packed {
		logic [1:0] cmd;
		logic [4:0] clock_hours;
		logic [5:0] clock_minutes;
		logic [5:0] clock_seconds;
		logic [4:0] clock_day;
		logic [3:0] clock_month;
		logic       alarm_ok;
	} item_t;

	typedef struct packed {
		logic [3:0]  mode;
		logic [2:0]  edit_field;
		logic        blink_on;
		logic [4:0]  show_hours;
		logic [5:0]  show_minutes;
		logic [5:0]  show_seconds;
		logic [4:0]  show_day;
		logic [3:0]  show_month;
		logic [12:0] stopwatch_seconds;
		logic [12:0] timer_seconds;
		logic        alarm_armed;
		logic [2:0]  event_res;
	} result_t;

endpackage

@@ rtl/wmc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmc_in_if / wmc_out_if
// Valid/ready channels for watch controller items and results.
// ----------------------------------------------------------------------------
interface wmc_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [4:0] clock_hours;
	logic [5:0] clock_minutes;
	logic [5:0] clock_seconds;
	logic [4:0] clock_day;
	logic [3:0] clock_month;
	logic       alarm_ok;

	modport source (
		output valid, cmd, clock_hours, clock_minutes, clock_seconds,
		       clock_day, clock_month, alarm_ok,
		input  ready
	);
	modport sink (
		input  valid, cmd, clock_hours, clock_minutes, clock_seconds,
		       clock_day, clock_month, alarm_ok,
		output ready
	);
endinterface

interface wmc_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  mode;
	logic [2:0]  edit_field;
	logic        blink_on;
	logic [4:0]  show_hours;
	logic [5:0]  show_minutes;
	logic [5:0]  show_seconds;
	logic [4:0]  show_day;
	logic [3:0]  show_month;
	logic [12:0] stopwatch_seconds;
	logic [12:0] timer_seconds;
	logic        alarm_armed;
	logic [2:0]  event_res;

	modport source (
		output valid, mode, edit_field, blink_on, show_hours, show_minutes,
		       show_seconds, show_day, show_month, stopwatch_seconds,
		       timer_seconds, alarm_armed, event_res,
		input  ready
	);
	modport sink (
		input  valid, mode, edit_field, blink_on, show_hours, show_minutes,
		       show_seconds, show_day, show_month, stopwatch_seconds,
		       timer_seconds, alarm_armed, event_res,
		output ready
	);
endinterface

@@ rtl/wmc_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmc_core
// Watch controller state and its combinational update for one item.
// ----------------------------------------------------------------------------
module wmc_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  wmc_pkg::item_t   item,
	output wmc_pkg::result_t res
);
	import wmc_pkg::*;

	logic [3:0]  mode_q, mode_d;
	logic [2:0]  fld_q, fld_d;
	logic        blink_q, blink_d;
	logic [5:0]  e_sec_q, e_sec_d;
	logic [5:0]  e_min_q, e_min_d;
	logic [4:0]  e_hour_q, e_hour_d;
	logic [4:0]  e_day_q, e_day_d;
	logic [3:0]  e_month_q, e_month_d;
	logic [4:0]  ae_hour_q, ae_hour_d;
	logic [5:0]  ae_min_q, ae_min_d;
	logic [4:0]  al_hour_q, al_hour_d;
	logic [5:0]  al_min_q, al_min_d;
	logic        armed_q, armed_d;
	logic [31:0] stw_cnt_q, stw_cnt_d;
	logic [12:0] stw_mod_q, stw_mod_d;
	logic        stw_on_q, stw_on_d;
	logic [12:0] tmr_left_q, tmr_left_d;
	logic [12:0] tmr_set_q, tmr_set_d;
	logic        tmr_on_q, tmr_on_d;
	logic        tmr_hold_q, tmr_hold_d;
	logic [2:0]  ev;

	logic [4:0]  cday;
	logic [3:0]  cmonth;
	logic        edit_old, edit_new;
	logic [3:0]  fld_inc;
	logic [12:0] tmr_dec;
	logic [12:0] tmr_add;
	logic [6:0]  sec_inc, min_inc, amin_inc;
	logic [5:0]  hour_inc, ahour_inc;

	// clean up the clock date
	assign cday   = (item.clock_day == 5'd0) ? 5'd1 : item.clock_day;
	assign cmonth = (item.clock_month == 4'd0 || item.clock_month > MONTHS_YEAR) ?
	                4'd1 : item.clock_month;

	assign edit_old  = (mode_q == MODE_CLOCK_EDIT) || (mode_q == MODE_WAKE_EDIT);
	assign fld_inc   = {1'b0, fld_q} + 4'd1;
	assign tmr_dec   = (tmr_left_q != 13'd0) ? tmr_left_q - 13'd1 : 13'd0;
	assign tmr_add   = tmr_set_q + TMR_STEP;
	assign sec_inc   = {1'b0, e_sec_q} + 7'd1;
	assign min_inc   = {1'b0, e_min_q} + 7'd1;
	assign amin_inc  = {1'b0, ae_min_q} + 7'd1;
	assign hour_inc  = {1'b0, e_hour_q} + 6'd1;
	assign ahour_inc = {1'b0, ae_hour_q} + 6'd1;

	always_comb begin
		mode_d     = mode_q;
		fld_d      = fld_q;
		blink_d    = blink_q;
		e_sec_d    = e_sec_q;
		e_min_d    = e_min_q;
		e_hour_d   = e_hour_q;
		e_day_d    = e_day_q;
		e_month_d  = e_month_q;
		ae_hour_d  = ae_hour_q;
		ae_min_d   = ae_min_q;
		al_hour_d  = al_hour_q;
		al_min_d   = al_min_q;
		armed_d    = armed_q;
		stw_cnt_d  = stw_cnt_q;
		stw_mod_d  = stw_mod_q;
		stw_on_d   = stw_on_q;
		tmr_left_d = tmr_left_q;
		tmr_set_d  = tmr_set_q;
		tmr_on_d   = tmr_on_q;
		tmr_hold_d = tmr_hold_q;
		ev         = EV_NONE;

		case (item.cmd)
			CMD_TICK: begin
				if (edit_old) begin
					blink_d = ~blink_q;
				end
				if (stw_on_q) begin
					stw_cnt_d = stw_cnt_q + 32'd1;
					// a wrap of the full count restarts the display count too
					if (stw_cnt_q == 32'hFFFF_FFFF || stw_mod_q == STW_LAST) begin
						stw_mod_d = 13'd0;
					end else begin
						stw_mod_d = stw_mod_q + 13'd1;
					end
				end
				if (tmr_on_q) begin
					tmr_left_d = tmr_dec;
					if (tmr_dec == 13'd0) begin
						tmr_on_d   = 1'b0;
						tmr_hold_d = 1'b0;
						ev         = EV_TMR_EXPIRED;
					end
				end
			end
			CMD_MODE: begin
				unique case (mode_q)
					MODE_CLOCK_EDIT: begin
						fld_d   = (fld_inc >= 4'(TIME_FIELDS)) ?
						          3'(fld_inc - 4'(TIME_FIELDS)) : fld_inc[2:0];
						blink_d = 1'b1;
					end
					MODE_WAKE_EDIT: begin
						fld_d   = {2'b00, fld_inc[0]};
						blink_d = 1'b1;
					end
					MODE_CLOCK:     mode_d = MODE_WAKE;
					MODE_WAKE:      mode_d = MODE_CHRONO;
					MODE_CHRONO:    mode_d = MODE_COUNTDOWN;
					MODE_COUNTDOWN: mode_d = MODE_SENS0;
					MODE_SENS0:     mode_d = MODE_SENS1;
					MODE_SENS1:     mode_d = MODE_SENS2;
					MODE_SENS2:     mode_d = MODE_SENS3;
					default:        mode_d = MODE_CLOCK;
				endcase
			end
			CMD_ADJUST: begin
				unique case (mode_q)
					MODE_CLOCK: begin
						e_hour_d  = item.clock_hours;
						e_min_d   = item.clock_minutes;
						e_sec_d   = item.clock_seconds;
						e_day_d   = cday;
						e_month_d = cmonth;
						fld_d     = FLD_SEC;
						blink_d   = 1'b1;
						mode_d    = MODE_CLOCK_EDIT;
					end
					MODE_CLOCK_EDIT: begin
						mode_d = MODE_CLOCK;
						ev     = EV_COMMIT_TIME;
					end
					MODE_WAKE: begin
						ae_hour_d = al_hour_q;
						ae_min_d  = al_min_q;
						fld_d     = 3'd0;
						blink_d   = 1'b1;
						mode_d    = MODE_WAKE_EDIT;
					end
					MODE_WAKE_EDIT: begin
						al_hour_d = ae_hour_q;
						al_min_d  = ae_min_q;
						armed_d   = item.alarm_ok;
						mode_d    = MODE_WAKE;
						ev        = EV_COMMIT_ALARM;
					end
					MODE_CHRONO: stw_on_d = ~stw_on_q;
					MODE_COUNTDOWN: begin
						if (tmr_on_q) begin
							tmr_on_d   = 1'b0;
							tmr_hold_d = 1'b1;
						end else begin
							if (!tmr_hold_q) begin
								tmr_left_d = tmr_set_q;
							end
							tmr_on_d   = 1'b1;
							tmr_hold_d = 1'b0;
						end
					end
					default: ;
				endcase
			end
			default: begin
				unique case (mode_q)
					MODE_CLOCK_EDIT: begin
						case (fld_q)
							FLD_SEC: e_sec_d = (sec_inc >= {1'b0, SIXTY}) ?
							         6'(sec_inc - {1'b0, SIXTY}) : sec_inc[5:0];
							FLD_MIN: e_min_d = (min_inc >= {1'b0, SIXTY}) ?
							         6'(min_inc - {1'b0, SIXTY}) : min_inc[5:0];
							FLD_HOUR: e_hour_d = (hour_inc >= {1'b0, HOURS_DAY}) ?
							          5'(hour_inc - {1'b0, HOURS_DAY}) : hour_inc[4:0];
							FLD_DAY: e_day_d = (e_day_q == DAYS_MAX) ?
							         5'd1 : e_day_q + 5'd1;
							FLD_MONTH: e_month_d = (e_month_q >= MONTHS_YEAR) ?
							           e_month_q - MONTHS_YEAR + 4'd1 : e_month_q + 4'd1;
							default: ;
						endcase
						blink_d = 1'b1;
					end
					MODE_WAKE_EDIT: begin
						if (fld_q == 3'd0) begin
							ae_hour_d = (ahour_inc >= {1'b0, HOURS_DAY}) ?
							            5'(ahour_inc - {1'b0, HOURS_DAY}) : ahour_inc[4:0];
						end else begin
							ae_min_d = (amin_inc >= {1'b0, SIXTY}) ?
							           6'(amin_inc - {1'b0, SIXTY}) : amin_inc[5:0];
						end
						blink_d = 1'b1;
					end
					MODE_CHRONO: begin
						if (!stw_on_q) begin
							stw_cnt_d = 32'd0;
							stw_mod_d = 13'd0;
						end
					end
					MODE_COUNTDOWN: begin
						if (!tmr_on_q) begin
							tmr_set_d  = (tmr_add > TMR_MAX) ? TMR_MIN : tmr_add;
							tmr_left_d = 13'd0;
							tmr_hold_d = 1'b0;
						end
					end
					MODE_WAKE: begin
						if (armed_q) begin
							armed_d = 1'b0;
							ev      = EV_DISARM;
						end else begin
							armed_d = item.alarm_ok;
							ev      = EV_COMMIT_ALARM;
						end
					end
					default: ;
				endcase
			end
		endcase
	end

	assign edit_new = (mode_d == MODE_CLOCK_EDIT) || (mode_d == MODE_WAKE_EDIT);

	always_comb begin
		res.mode              = mode_d;
		res.edit_field        = edit_new ? fld_d : 3'd0;
		res.blink_on          = edit_new ? blink_d : 1'b1;
		res.show_hours        = item.clock_hours;
		res.show_minutes      = item.clock_minutes;
		res.show_seconds      = item.clock_seconds;
		res.show_day          = cday;
		res.show_month        = cmonth;
		res.stopwatch_seconds = stw_mod_d;
		res.timer_seconds     = (tmr_on_d || tmr_hold_d) ? tmr_left_d : tmr_set_d;
		res.alarm_armed       = armed_d;
		res.event_res         = ev;
		if (mode_d == MODE_CLOCK_EDIT || ev == EV_COMMIT_TIME) begin
			res.show_hours   = e_hour_d;
			res.show_minutes = e_min_d;
			res.show_seconds = e_sec_d;
			res.show_day     = e_day_d;
			res.show_month   = e_month_d;
		end else if (mode_d == MODE_WAKE) begin
			res.show_hours   = al_hour_d;
			res.show_minutes = al_min_d;
			res.show_seconds = 6'd0;
		end else if (mode_d == MODE_WAKE_EDIT) begin
			res.show_hours   = ae_hour_d;
			res.show_minutes = ae_min_d;
			res.show_seconds = 6'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_CLOCK_EDIT;
			fld_q      <= FLD_SEC;
			blink_q    <= 1'b1;
			e_sec_q    <= 6'd0;
			e_min_q    <= 6'd0;
			e_hour_q   <= 5'd0;
			e_day_q    <= 5'd1;
			e_month_q  <= 4'd1;
			ae_hour_q  <= 5'd0;
			ae_min_q   <= 6'd0;
			al_hour_q  <= 5'd6;
			al_min_q   <= 6'd30;
			armed_q    <= 1'b0;
			stw_cnt_q  <= 32'd0;
			stw_mod_q  <= 13'd0;
			stw_on_q   <= 1'b0;
			tmr_left_q <= 13'd0;
			tmr_set_q  <= TMR_MIN;
			tmr_on_q   <= 1'b0;
			tmr_hold_q <= 1'b0;
		end else if (step) begin
			mode_q     <= mode_d;
			fld_q      <= fld_d;
			blink_q    <= blink_d;
			e_sec_q    <= e_sec_d;
			e_min_q    <= e_min_d;
			e_hour_q   <= e_hour_d;
			e_day_q    <= e_day_d;
			e_month_q  <= e_month_d;
			ae_hour_q  <= ae_hour_d;
			ae_min_q   <= ae_min_d;
			al_hour_q  <= al_hour_d;
			al_min_q   <= al_min_d;
			armed_q    <= armed_d;
			stw_cnt_q  <= stw_cnt_d;
			stw_mod_q  <= stw_mod_d;
			stw_on_q   <= stw_on_d;
			tmr_left_q <= tmr_left_d;
			tmr_set_q  <= tmr_set_d;
			tmr_on_q   <= tmr_on_d;
			tmr_hold_q <= tmr_hold_d;
		end
	end

endmodule

@@ rtl/watch_mode_controller_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// watch_mode_controller_top
// Three-key watch controller: modes, editors, stopwatch, timer and alarm.
//
//   port    dir   handshake     carries
//   item    in    valid/ready   tick or key press plus current clock values
//   result  out   valid/ready   shown values and one event per item
//
// One result per item, passed through the input register and then the output register.
// One item per cycle sustained while results are taken: the state update is a single register pass.
// Reset puts the controller in time set with stopwatch and timer idle.
// A stalled result holds in the output register; one more item waits in the
// input register before ready drops.
// ----------------------------------------------------------------------------
module watch_mode_controller_top (
	input logic      clk,
	input logic      arst_n,
	wmc_in_if.sink   item,
	wmc_out_if.source result
);
	import wmc_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    res_valid_s2;
	result_t res_s2;
	result_t core_res;
	logic    adv;

	assign adv        = valid_s1 && (!res_valid_s2 || result.ready);
	assign item.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			res_valid_s2 <= 1'b0;
		end else begin
			if (item.ready) begin
				valid_s1 <= item.valid;
			end
			if (!res_valid_s2 || result.ready) begin
				res_valid_s2 <= valid_s1;
			end
		end
	end

	// capture on transfer
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.cmd           <= item.cmd;
			item_s1.clock_hours   <= item.clock_hours;
			item_s1.clock_minutes <= item.clock_minutes;
			item_s1.clock_seconds <= item.clock_seconds;
			item_s1.clock_day     <= item.clock_day;
			item_s1.clock_month   <= item.clock_month;
			item_s1.alarm_ok      <= item.alarm_ok;
		end
		if (adv) begin
			res_s2 <= core_res;
		end
	end

	wmc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.res    (core_res)
	);

	assign result.valid             = res_valid_s2;
	assign result.mode              = res_s2.mode;
	assign result.edit_field        = res_s2.edit_field;
	assign result.blink_on          = res_s2.blink_on;
	assign result.show_hours        = res_s2.show_hours;
	assign result.show_minutes      = res_s2.show_minutes;
	assign result.show_seconds      = res_s2.show_seconds;
	assign result.show_day          = res_s2.show_day;
	assign result.show_month        = res_s2.show_month;
	assign result.stopwatch_seconds = res_s2.stopwatch_seconds;
	assign result.timer_seconds     = res_s2.timer_seconds;
	assign result.alarm_armed       = res_s2.alarm_armed;
	assign result.event_res         = res_s2.event_res;

endmodule
